[sv/rrts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned IDX_W     = $clog2(NUM_SLOTS);

  localparam logic [31:0] TIMER_CHAN = 32'h5449_4d45;
  localparam logic [31:0] PROC_CHAN  = 32'h5052_4f43;

  typedef enum logic [2:0] {
    ST_UNUSED  = 3'd0,
    ST_READY   = 3'd1,
    ST_RUNNING = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_DONE    = 3'd4
  } slot_st_e;

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_FULL    = 3'd1,
    ERR_BOOT    = 3'd2,
    ERR_NORUN   = 3'd3,
    ERR_NOCHILD = 3'd4
  } err_e;

  typedef enum logic [3:0] {
    OP_TICK   = 4'd0,
    OP_CREATE = 4'd1,
    OP_SLEEP  = 4'd2,
    OP_EXITST = 4'd3,
    OP_WAIT   = 4'd4,
    OP_BLOCK  = 4'd5,
    OP_WAKE1  = 4'd6,
    OP_WAKEA  = 4'd7,
    OP_COUNT  = 4'd8,
    OP_EXIT   = 4'd9
  } op_e;

  // datapath action for one cycle
  typedef enum logic [3:0] {
    A_NONE, A_START, A_TICK_SCAN, A_TICK_CUR, A_PICK, A_CREATE, A_SLEEP,
    A_EXIT_WR, A_EXIT_SCAN, A_REAP, A_WAIT_SCAN, A_WAIT_BLK, A_BLOCK,
    A_WAKE, A_COUNT, A_PEXIT
  } act_e;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] channel;
    logic [31:0] sleep_ticks;
    logic [63:0] exit_code;
    logic [31:0] wait_tid;
    logic [31:0] owner_tid;
    logic        user_task;
  } in_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic [31:0] current_id;
    logic [63:0] value;
    logic [31:0] woken_id;
    logic        woken_valid;
    logic        switched;
  } out_t;

  typedef struct packed {
    logic cap;        // latch input item
    act_e act;
    logic init_lin;   // scan from slot 0
    logic init_pick;  // scan from the slot after the current one
    logic out_load;   // load result register
  } cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       boot;
    logic       hit;
    logic       hit_done;
    logic       last;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

[sv/rrts_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer: steps the datapath through the scans of one command.
// ----------------------------------------------------------------------------
module rrts_ctrl import rrts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_TICK_SCAN, S_TICK_CUR, S_PICK, S_CREATE, S_SLEEP,
    S_EXIT_WR, S_EXIT_SCAN, S_REAP, S_WAIT_SCAN, S_WAIT_BLK, S_BLOCK,
    S_WAKE, S_COUNT, S_PEXIT, S_OUT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '{cap: 1'b0, act: A_NONE, init_lin: 1'b0, init_pick: 1'b0,
                out_load: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_START;
        end
      end
      S_START: begin
        cmd_o.act      = A_START;
        cmd_o.init_lin = 1'b1;
        if (sts_i.boot) begin
          state_d = S_OUT;
        end else begin
          unique case (sts_i.op)
            OP_TICK:           state_d = S_TICK_SCAN;
            OP_CREATE:         state_d = S_CREATE;
            OP_SLEEP:          state_d = S_SLEEP;
            OP_EXITST:         state_d = S_EXIT_WR;
            OP_WAIT:           state_d = S_WAIT_SCAN;
            OP_BLOCK:          state_d = S_BLOCK;
            OP_WAKE1, OP_WAKEA: state_d = S_WAKE;
            OP_COUNT:          state_d = S_COUNT;
            OP_EXIT:           state_d = S_PEXIT;
            default:           state_d = S_OUT;
          endcase
        end
      end
      S_TICK_SCAN: begin
        cmd_o.act = A_TICK_SCAN;
        if (sts_i.last) state_d = S_TICK_CUR;
      end
      S_TICK_CUR: begin
        cmd_o.act       = A_TICK_CUR;
        cmd_o.init_pick = 1'b1;
        state_d         = S_PICK;
      end
      S_PICK: begin
        cmd_o.act = A_PICK;
        if (sts_i.hit || sts_i.last) state_d = S_OUT;
      end
      S_CREATE: begin
        cmd_o.act = A_CREATE;
        if (sts_i.hit || sts_i.last) state_d = S_OUT;
      end
      S_SLEEP: begin
        cmd_o.act       = A_SLEEP;
        cmd_o.init_pick = 1'b1;
        state_d         = S_PICK;
      end
      S_EXIT_WR: begin
        cmd_o.act      = A_EXIT_WR;
        cmd_o.init_lin = 1'b1;
        state_d        = S_EXIT_SCAN;
      end
      S_EXIT_SCAN: begin
        cmd_o.act = A_EXIT_SCAN;
        if (sts_i.hit) begin
          state_d = S_REAP;
        end else if (sts_i.last) begin
          cmd_o.init_pick = 1'b1;
          state_d         = S_PICK;
        end
      end
      S_REAP: begin
        cmd_o.act       = A_REAP;
        cmd_o.init_pick = 1'b1;
        state_d         = S_PICK;
      end
      S_WAIT_SCAN: begin
        cmd_o.act = A_WAIT_SCAN;
        if (sts_i.hit) begin
          state_d = sts_i.hit_done ? S_OUT : S_WAIT_BLK;
        end else if (sts_i.last) begin
          state_d = S_OUT;
        end
      end
      S_WAIT_BLK: begin
        cmd_o.act       = A_WAIT_BLK;
        cmd_o.init_pick = 1'b1;
        state_d         = S_PICK;
      end
      S_BLOCK: begin
        cmd_o.act       = A_BLOCK;
        cmd_o.init_pick = 1'b1;
        state_d         = S_PICK;
      end
      S_WAKE: begin
        cmd_o.act = A_WAKE;
        if ((sts_i.hit && sts_i.op == OP_WAKE1) || sts_i.last) state_d = S_OUT;
      end
      S_COUNT: begin
        cmd_o.act = A_COUNT;
        if (sts_i.last) state_d = S_OUT;
      end
      S_PEXIT: begin
        cmd_o.act = A_PEXIT;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[sv/rrts_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_datapath
// Slot table, scan counters, scheduler registers and result register.
// ----------------------------------------------------------------------------
module rrts_datapath import rrts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire in_t  in_data_i,
  input  wire cmd_t cmd_i,
  output sts_t      sts_o,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  output out_t      out_data_o
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  in_t              in_q;
  logic [IDX_W-1:0] cur_q, cur_d, prev_q, idx_q, cnt_q, addr;
  logic [31:0]      cur_id_q, cur_par_q, nid_q, nid_d, wid_q, wid_d;
  logic [63:0]      tick_q, tick_d, val_q, val_d;
  err_e             err_q, err_d;
  logic             wv_q, wv_d;
  out_t             out_q;
  logic             out_v_q;

  // slot table
  slot_st_e    tb_st_q   [NUM_SLOTS];
  logic [31:0] tb_id_q   [NUM_SLOTS];
  logic [31:0] tb_par_q  [NUM_SLOTS];
  logic [31:0] tb_ch_q   [NUM_SLOTS];
  logic [31:0] tb_wc_q   [NUM_SLOTS];
  logic [63:0] tb_wake_q [NUM_SLOTS];
  logic [63:0] tb_stat_q [NUM_SLOTS];
  logic        tb_rp_q   [NUM_SLOTS];

  slot_st_e    rd_st;
  logic [31:0] rd_id, rd_par, rd_ch, rd_wc;
  logic [63:0] rd_wake, rd_stat;
  logic        rd_rp;

  logic        we_st, we_id, we_par, we_ch, we_wc, we_wake, we_stat, we_rp;
  slot_st_e    st_wd;
  logic [31:0] ch_wd, wc_wd;
  logic [63:0] wake_wd;
  logic        hit, hit_done, last, blk_op, sel_cur;
  logic [63:0] ticks;

  // acts on the current slot address it, the rest the scan index
  assign sel_cur = (cmd_i.act == A_START) || (cmd_i.act == A_TICK_CUR) ||
                   (cmd_i.act == A_SLEEP) || (cmd_i.act == A_EXIT_WR) ||
                   (cmd_i.act == A_REAP) || (cmd_i.act == A_WAIT_BLK) ||
                   (cmd_i.act == A_BLOCK) || (cmd_i.act == A_PEXIT) ||
                   cmd_i.out_load;
  assign addr    = sel_cur ? cur_q : idx_q;

  assign rd_st   = tb_st_q[addr];
  assign rd_id   = tb_id_q[addr];
  assign rd_par  = tb_par_q[addr];
  assign rd_ch   = tb_ch_q[addr];
  assign rd_wc   = tb_wc_q[addr];
  assign rd_wake = tb_wake_q[addr];
  assign rd_stat = tb_stat_q[addr];
  assign rd_rp   = tb_rp_q[addr];

  assign last   = (cnt_q == LAST_IDX);
  assign blk_op = (in_q.op == OP_SLEEP) || (in_q.op == OP_EXITST) ||
                  (in_q.op == OP_WAIT) || (in_q.op == OP_BLOCK);
  assign ticks  = (in_q.sleep_ticks == '0) ? 64'd1 : {32'd0, in_q.sleep_ticks};

  always_comb begin
    cur_d = cur_q; nid_d = nid_q; tick_d = tick_q; val_d = val_q;
    err_d = err_q; wid_d = wid_q; wv_d = wv_q;
    we_st = 1'b0; we_id = 1'b0; we_par = 1'b0; we_ch = 1'b0;
    we_wc = 1'b0; we_wake = 1'b0; we_stat = 1'b0; we_rp = 1'b0;
    st_wd = ST_READY; ch_wd = '0; wc_wd = '0; wake_wd = '0;
    hit = 1'b0; hit_done = 1'b0;
    unique case (cmd_i.act)
      A_START: begin
        err_d = (blk_op && cur_q == '0) ? ERR_BOOT : ERR_OK;
        val_d = '0; wid_d = '0; wv_d = 1'b0;
        if (in_q.op == OP_TICK) tick_d = tick_q + 64'd1;
      end
      A_TICK_SCAN: begin
        hit = (rd_st == ST_BLOCKED) && (rd_ch == TIMER_CHAN) && (rd_wake <= tick_q);
        if (hit) begin
          we_st = 1'b1; we_ch = 1'b1; we_wake = 1'b1;
        end
      end
      A_TICK_CUR: begin
        if (rd_st == ST_RUNNING) we_st = 1'b1;
      end
      A_PICK: begin
        hit = (rd_st == ST_READY);
        st_wd = ST_RUNNING;
        if (hit) begin
          we_st = 1'b1;
          cur_d = idx_q;
        end else if (last) begin
          // last step looks at the current slot itself
          if (rd_st == ST_BLOCKED || rd_st == ST_DONE) err_d = ERR_NORUN;
          else we_st = 1'b1;
        end
      end
      A_CREATE: begin
        hit = (rd_st == ST_UNUSED) || (rd_st == ST_DONE && rd_rp);
        if (hit) begin
          we_st = 1'b1; we_id = 1'b1; we_par = 1'b1; we_ch = 1'b1;
          we_wc = 1'b1; we_wake = 1'b1; we_stat = 1'b1; we_rp = 1'b1;
          val_d = {32'd0, nid_q};
          nid_d = nid_q + 32'd1;
        end else if (last) begin
          err_d = ERR_FULL;
        end
      end
      A_SLEEP: begin
        we_st = 1'b1; st_wd = ST_BLOCKED;
        we_ch = 1'b1; ch_wd = TIMER_CHAN;
        we_wake = 1'b1; wake_wd = tick_q + ticks;
      end
      A_EXIT_WR: begin
        we_st = 1'b1; st_wd = ST_DONE;
        we_ch = 1'b1; we_wc = 1'b1; we_wake = 1'b1; we_stat = 1'b1;
      end
      A_EXIT_SCAN: begin
        hit = (rd_st == ST_BLOCKED) && (rd_ch == PROC_CHAN) && (rd_id == cur_par_q) &&
              ((rd_wc == '0) || (rd_wc == cur_id_q));
        if (hit) begin
          we_st = 1'b1; we_ch = 1'b1; we_wake = 1'b1; we_wc = 1'b1;
          wid_d = rd_id; wv_d = 1'b1; val_d = in_q.exit_code;
        end
      end
      A_REAP: begin
        we_rp = 1'b1;
      end
      A_WAIT_SCAN: begin
        hit = (rd_st != ST_UNUSED) && (rd_par == cur_id_q) && !rd_rp &&
              ((in_q.wait_tid == '0) || (rd_id == in_q.wait_tid));
        hit_done = hit && (rd_st == ST_DONE);
        if (hit_done) begin
          val_d = rd_stat;
          we_rp = 1'b1;
        end else if (!hit && last) begin
          err_d = ERR_NOCHILD;
          val_d = '1;
        end
      end
      A_WAIT_BLK: begin
        we_st = 1'b1; st_wd = ST_BLOCKED;
        we_ch = 1'b1; ch_wd = PROC_CHAN;
        we_wc = 1'b1; wc_wd = in_q.wait_tid;
        we_wake = 1'b1;
      end
      A_BLOCK: begin
        we_st = 1'b1; st_wd = ST_BLOCKED;
        we_ch = 1'b1; ch_wd = in_q.channel;
      end
      A_WAKE: begin
        hit = (rd_st == ST_BLOCKED) && (rd_ch == in_q.channel);
        if (hit) begin
          we_st = 1'b1; we_ch = 1'b1; we_wake = 1'b1;
          val_d = val_q + 64'd1;
        end
      end
      A_COUNT: begin
        hit = (rd_st == ST_BLOCKED) && (rd_ch == in_q.channel);
        if (hit) val_d = val_q + 64'd1;
      end
      A_PEXIT: begin
        we_st = 1'b1; st_wd = ST_DONE; we_ch = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts_o.op       = in_q.op;
    sts_o.boot     = blk_op && (cur_q == '0);
    sts_o.hit      = hit;
    sts_o.hit_done = hit_done;
    sts_o.last     = last;
    sts_o.out_free = !out_v_q || out_ready_i;
  end

  // table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tb_st_q[i]   <= (i == 0) ? ST_RUNNING : ST_UNUSED;
        tb_id_q[i]   <= '0;
        tb_par_q[i]  <= '0;
        tb_ch_q[i]   <= '0;
        tb_wc_q[i]   <= '0;
        tb_wake_q[i] <= '0;
        tb_stat_q[i] <= '0;
        tb_rp_q[i]   <= 1'b0;
      end
    end else begin
      if (we_st)   tb_st_q[addr]   <= st_wd;
      if (we_id)   tb_id_q[addr]   <= nid_q;
      if (we_par)  tb_par_q[addr]  <= in_q.owner_tid;
      if (we_ch)   tb_ch_q[addr]   <= ch_wd;
      if (we_wc)   tb_wc_q[addr]   <= wc_wd;
      if (we_wake) tb_wake_q[addr] <= wake_wd;
      if (we_stat) tb_stat_q[addr] <= (cmd_i.act == A_EXIT_WR) ? in_q.exit_code : '0;
      if (we_rp)   tb_rp_q[addr]   <= (cmd_i.act != A_CREATE);
    end
  end

  // scheduler registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      prev_q  <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      nid_q   <= 32'd1;
      tick_q  <= '0;
      err_q   <= ERR_OK;
      val_q   <= '0;
      wid_q   <= '0;
      wv_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      nid_q  <= nid_d;
      tick_q <= tick_d;
      err_q  <= err_d;
      val_q  <= val_d;
      wid_q  <= wid_d;
      wv_q   <= wv_d;
      if (cmd_i.act == A_START) prev_q <= cur_q;
      if (cmd_i.init_lin) begin
        idx_q <= '0;
        cnt_q <= '0;
      end else if (cmd_i.init_pick) begin
        idx_q <= (cur_q == LAST_IDX) ? '0 : cur_q + 1'b1;
        cnt_q <= '0;
      end else begin
        idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
        cnt_q <= last ? cnt_q : cnt_q + 1'b1;
      end
      if (cmd_i.out_load)          out_v_q <= 1'b1;
      else if (out_ready_i)        out_v_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) in_q <= in_data_i;
    if (cmd_i.act == A_START) begin
      cur_id_q  <= rd_id;
      cur_par_q <= rd_par;
    end
    if (cmd_i.out_load) begin
      out_q.error_code  <= err_q;
      out_q.current_id  <= rd_id;
      out_q.value       <= val_q;
      out_q.woken_id    <= wid_q;
      out_q.woken_valid <= wv_q;
      out_q.switched    <= (cur_q != prev_q);
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[sv/round_robin_task_scheduler_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Task slot table with round-robin choice of the running task.
// ----------------------------------------------------------------------------
// One command item in, one result item out. Commands run one at a time: a
// slot table of NUM_SLOTS entries is read and written through a single
// port, so each scan walks the slots one a cycle and looks at no more than
// NUM_SLOTS slots. A command is captured and set up in a start step, then
// runs its scans: create and wake-one stop at the first hit, while tick
// and exit with status run a wake scan followed by the round-robin pick.
// A new item is taken once the previous command is finished; its result
// may still sit in the output register.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_unit import rrts_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  cmd_t cmd;   // controller to datapath
  sts_t sts;   // datapath flags back

  // sequencer
  rrts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table, scheduler state and result register
  rrts_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
